// File: hw/rtl/edu_pkg.sv
// ----------------------------------------------------------------------------
// edu_pkg : shared constants and types of the Euclidean distance unit
// Widths of the element path, accumulator and root, and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package edu_pkg;

    localparam int ELEM_W  = 16;                // element width, signed Q8.8
    localparam int DIFF_W  = ELEM_W + 1;        // magnitude of a - b
    localparam int SQ_W    = 2 * DIFF_W;        // square of the magnitude
    localparam int ACC_W   = 46;                // sum of squares, Q30.16
    localparam int ROOT_W  = ACC_W / 2;         // root bits, one per step
    localparam int REM_W   = ROOT_W + 3;        // partial remainder
    localparam int CNT_W   = $clog2(ROOT_W);    // root step counter
    localparam int TDATA_IN_W  = 2 * ELEM_W;
    localparam int TDATA_OUT_W = ((ROOT_W + 7) / 8) * 8;

    // Controller to datapath
    typedef struct packed {
        logic accept;       // take the beat on the slave side
        logic load_root;    // copy the sum into the root unit, clear the sum
        logic root_step;    // resolve one root bit
        logic load_out;     // move the root into the output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic last_sum;     // the last square of a vector is being added
        logic out_free;     // output register can take a result this cycle
    } stat_t;

endpackage

// File: hw/rtl/edu_ctrl.sv
// ----------------------------------------------------------------------------
// edu_ctrl : sequencer of the Euclidean distance unit
// Admits element beats, waits for the last square to land, runs the
// bit-serial square root and hands the result to the output register.
// ----------------------------------------------------------------------------
module edu_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_last,
    input  edu_pkg::stat_t stat,
    output logic          in_ready,
    output edu_pkg::cmd_t cmd
);

    localparam logic [2:0] ST_ACC   = 3'd0;
    localparam logic [2:0] ST_DRAIN = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_ROOT  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam logic [edu_pkg::CNT_W-1:0] LAST_STEP =
        edu_pkg::CNT_W'(edu_pkg::ROOT_W - 1);

    logic [2:0]                state_reg, state_next;
    logic [edu_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    assign in_ready = (state_reg == ST_ACC);

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cmd.accept    = 1'b0;
        cmd.load_root = 1'b0;
        cmd.root_step = 1'b0;
        cmd.load_out  = 1'b0;
        case (state_reg)
            ST_ACC:
            begin
                cmd.accept = in_valid;
                if (in_valid && in_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (stat.last_sum)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.load_root = 1'b1;
                cnt_next      = LAST_STEP;
                state_next    = ST_ROOT;
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_ACC;
                end
            end
            default:
            begin
                state_next = ST_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACC;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// File: hw/rtl/edu_datapath.sv
// ----------------------------------------------------------------------------
// edu_datapath : arithmetic of the Euclidean distance unit
// Difference magnitude, registered square, saturating accumulator,
// restoring square root one bit a cycle, and the output register.
// ----------------------------------------------------------------------------
module edu_datapath
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [edu_pkg::ELEM_W-1:0]   element_a,
    input  logic [edu_pkg::ELEM_W-1:0]   element_b,
    input  logic                         last_element,
    input  edu_pkg::cmd_t                cmd,
    input  logic                         out_ready,
    output edu_pkg::stat_t               stat,
    output logic                         out_valid,
    output logic [edu_pkg::ROOT_W-1:0]   distance,
    output logic                         saturated
);

    // Stage 1: magnitude of the difference
    logic signed [edu_pkg::DIFF_W-1:0] diff;
    logic [edu_pkg::DIFF_W-1:0]        mag;
    logic [edu_pkg::DIFF_W-1:0]        mag_reg;
    logic                              v1_reg, last1_reg;

    // Stage 2: square
    logic [edu_pkg::SQ_W-1:0]          sq_reg;
    logic                              v2_reg, last2_reg;

    // Accumulator
    logic [edu_pkg::ACC_W-1:0]         acc_reg;
    logic                              ovf_reg;
    logic [edu_pkg::ACC_W:0]           sum;

    // Root unit
    logic [edu_pkg::ACC_W-1:0]         rad_reg;
    logic [edu_pkg::REM_W-1:0]         rem_reg;
    logic [edu_pkg::ROOT_W-1:0]        root_reg;
    logic                              root_sat_reg;
    logic [edu_pkg::REM_W-1:0]         rem_shift, trial;
    logic                              fits;

    // Output register
    logic                              out_valid_reg;
    logic [edu_pkg::ROOT_W-1:0]        dist_reg;
    logic                              sat_reg;

    function automatic logic signed [edu_pkg::DIFF_W-1:0] DIFF_W_SEXT
        (input logic [edu_pkg::ELEM_W-1:0] x);
        return {x[edu_pkg::ELEM_W-1], x};
    endfunction

    assign diff = DIFF_W_SEXT(element_a) - DIFF_W_SEXT(element_b);
    assign mag  = diff[edu_pkg::DIFF_W-1] ? edu_pkg::DIFF_W'(-diff)
                                          : edu_pkg::DIFF_W'(diff);

    assign sum = {1'b0, acc_reg} + (edu_pkg::ACC_W + 1)'(sq_reg);

    assign rem_shift = {rem_reg[edu_pkg::REM_W-3:0],
                        rad_reg[edu_pkg::ACC_W-1 -: 2]};
    assign trial     = edu_pkg::REM_W'({root_reg, 2'b01});
    assign fits      = (rem_shift >= trial);

    assign stat.last_sum = v2_reg && last2_reg;
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign distance  = dist_reg;
    assign saturated = sat_reg;

    // Control: pipeline valids, accumulator, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.accept;
            v2_reg <= v1_reg;
            if (cmd.load_root)
            begin
                acc_reg <= '0;
                ovf_reg <= 1'b0;
            end
            else if (v2_reg)
            begin
                if (sum[edu_pkg::ACC_W])
                begin
                    acc_reg <= '1;
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    acc_reg <= sum[edu_pkg::ACC_W-1:0];
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        mag_reg   <= mag;
        last1_reg <= last_element;
        sq_reg    <= mag_reg * mag_reg;
        last2_reg <= last1_reg;
        if (cmd.load_root)
        begin
            rad_reg      <= acc_reg;
            rem_reg      <= '0;
            root_reg     <= '0;
            root_sat_reg <= ovf_reg;
        end
        else if (cmd.root_step)
        begin
            rad_reg  <= {rad_reg[edu_pkg::ACC_W-3:0], 2'b00};
            rem_reg  <= fits ? (rem_shift - trial) : rem_shift;
            root_reg <= {root_reg[edu_pkg::ROOT_W-2:0], fits};
        end
        if (cmd.load_out)
        begin
            dist_reg <= root_reg;
            sat_reg  <= root_sat_reg;
        end
    end

endmodule

// File: hw/rtl/euclidean_distance_unit.sv
// ----------------------------------------------------------------------------
// euclidean_distance_unit : streaming L2 distance of signed Q8.8 vectors
// Sums squared element differences and returns the truncated square root.
// ----------------------------------------------------------------------------
// One element pair is taken per beat, one beat per cycle, while a vector
// streams in. The difference is squared exactly and added into a 46-bit
// accumulator that holds at its maximum and raises the saturated flag if
// the sum would pass it. The beat carrying tlast closes the vector: input
// is then held off while the last square drains through the magnitude
// and square registers, the sum moves to the root unit, the restoring
// square root resolves one bit per cycle and the result enters the
// output register once it is free; the root iteration sets the
// per-vector overhead. A finished result waits in the output register
// while the next vector streams in. The distance is floor(sqrt(sum)),
// unsigned Q15.8, never rounded up; the accumulator and flag are cleared
// for the next vector.
// ----------------------------------------------------------------------------
module euclidean_distance_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    // slave side: element pairs
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: element_a [15:0], element_b [31:16]
    input  logic [edu_pkg::TDATA_IN_W-1:0]    s_axis_tdata,
    input  logic                              s_axis_tlast,   // last_element
    // master side: distances
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: distance [22:0], zero [23]
    output logic [edu_pkg::TDATA_OUT_W-1:0]   m_axis_tdata,
    // tuser: saturated [0]
    output logic                              m_axis_tuser
);

    edu_pkg::cmd_t              cmd;
    edu_pkg::stat_t             stat;
    logic [edu_pkg::ROOT_W-1:0] distance;

    // Sequencer: admit beats, then drain, root and hand over
    edu_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_last  (s_axis_tlast),
        .stat     (stat),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    // Arithmetic: split the beat into its two elements
    edu_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .element_a    (s_axis_tdata[edu_pkg::ELEM_W-1:0]),
        .element_b    (s_axis_tdata[edu_pkg::TDATA_IN_W-1:edu_pkg::ELEM_W]),
        .last_element (s_axis_tlast),
        .cmd          (cmd),
        .out_ready    (m_axis_tready),
        .stat         (stat),
        .out_valid    (m_axis_tvalid),
        .distance     (distance),
        .saturated    (m_axis_tuser)
    );

    // Pad the distance up to whole bytes
    assign m_axis_tdata = edu_pkg::TDATA_OUT_W'(distance);

endmodule

// File: bench/tb_euclidean_distance_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_euclidean_distance_unit : self-checking bench for the L2 distance unit
// Streams element pairs into the unit and keeps a bit-exact copy of its sum of
// squares and saturation flag. Every distance beat on the master side is
// checked against the oldest distance that this copy has worked out. Directed
// extremes and a long full-scale vector come first, then random vectors, with
// both sides stalling at random.
// ----------------------------------------------------------------------------
module tb_euclidean_distance_unit;

    import edu_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int LONG_LENGTH = 500;       // full-scale pairs, sum close to 2^41
    localparam int DRAIN_WAIT  = 40;        // root iteration plus output register, with margin
    localparam int REPORT_MAX  = 10;

    localparam logic [63:0] ACC_FULL = (64'd1 << ACC_W) - 64'd1;
    localparam logic signed [ELEM_W-1:0] MOST_NEG = {1'b1, {(ELEM_W - 1){1'b0}}};
    localparam logic signed [ELEM_W-1:0] MOST_POS = {1'b0, {(ELEM_W - 1){1'b1}}};

    typedef struct packed {
        logic [ROOT_W-1:0] distance;
        logic              saturated;
    } dist_result_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // tdata: element_a [15:0], element_b [31:16]
    logic [TDATA_IN_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tlast  = 1'b0;   // last_element
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // tdata: distance [22:0], zero [23]
    logic [TDATA_OUT_W-1:0] m_axis_tdata;
    // tuser: saturated [0]
    logic                   m_axis_tuser;

    // Bench copy of the unit's state
    logic [ACC_W-1:0] running_sum = '0;
    logic             sum_clipped = 1'b0;

    // Distances owed by the unit, oldest first
    dist_result_t distances_due[$];

    int  mismatches     = 0;
    int  pairs_sent     = 0;
    int  vectors_sent   = 0;
    int  distances_seen = 0;
    int  clipped_seen   = 0;
    bit  quiet          = 1'b0;   // set for a stretch with no stalls on either side

    euclidean_distance_unit uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Truncated square root, one bit per step from the top; never rounds up.
    function automatic logic [ROOT_W-1:0] floor_root(input logic [63:0] sum);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = ROOT_W - 1; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= sum)
                root = trial;
        end
        return root[ROOT_W-1:0];
    endfunction

    // Add one pair's squared difference; on the closing pair queue the distance
    // and clear the sum and flag for the next vector.
    task automatic accumulate_pair(input logic signed [ELEM_W-1:0] a,
                                   input logic signed [ELEM_W-1:0] b,
                                   input logic                     last);
        longint       diff;
        logic [63:0]  mag;
        logic [63:0]  square;
        dist_result_t owed;
        diff = longint'(a) - longint'(b);
        mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
        square = mag * mag;
        // A magnitude past 32 bits cannot be squared in 64; treat it as saturating.
        if (mag > 64'hFFFF_FFFF || square > ACC_FULL - 64'(running_sum))
        begin
            running_sum = ACC_W'(ACC_FULL);
            sum_clipped = 1'b1;
        end
        else
        begin
            running_sum = running_sum + ACC_W'(square);
        end
        if (last)
        begin
            owed.distance  = floor_root(64'(running_sum));
            owed.saturated = sum_clipped;
            distances_due.push_back(owed);
            running_sum = '0;
            sum_clipped = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Slave side: one pair per call
    // ------------------------------------------------------------------------

    // Idle at random first, with noise on the data lines, then hold the beat
    // until the unit takes it. Valid is left high for the next call.
    task automatic send_pair(input logic signed [ELEM_W-1:0] a,
                             input logic signed [ELEM_W-1:0] b,
                             input logic                     last);
        while (!quiet && $urandom_range(99) < 11)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom;
            s_axis_tlast  <= 1'($urandom_range(1));
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        accumulate_pair(a, b, last);
        pairs_sent++;
        if (last)
            vectors_sent++;
    endtask

    // Drop valid and wait until every owed distance has come out.
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        while (distances_due.size() != 0)
            @(posedge clk);
    endtask

    // Mix of extremes, values near zero and full-range noise.
    function automatic logic signed [ELEM_W-1:0] pick_element();
        case ($urandom_range(7))
            0:       return MOST_NEG;
            1:       return MOST_POS;
            2, 3:    return ELEM_W'(int'($urandom_range(16)) - 8);
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Master side: random back-pressure and the result check
    // ------------------------------------------------------------------------

    function automatic void flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("MISMATCH at %0t: %s", $realtime, what);
    endfunction

    // Check with the values seen at this edge, then pick the next ready.
    always @(posedge clk)
    begin
        dist_result_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            distances_seen++;
            if (m_axis_tuser)
                clipped_seen++;
            if (distances_due.size() == 0)
            begin
                flag_mismatch($sformatf("distance beat with none owed: tdata %h tuser %b",
                                        m_axis_tdata, m_axis_tuser));
            end
            else
            begin
                want = distances_due.pop_front();
                if (m_axis_tdata[ROOT_W-1:0] !== want.distance)
                    flag_mismatch($sformatf("distance expected %0d got %0d",
                                            want.distance, m_axis_tdata[ROOT_W-1:0]));
                if (m_axis_tuser !== want.saturated)
                    flag_mismatch($sformatf("saturated expected %b got %b",
                                            want.saturated, m_axis_tuser));
                if (m_axis_tdata[TDATA_OUT_W-1:ROOT_W] !== '0)
                    flag_mismatch($sformatf("tdata padding not zero: %h", m_axis_tdata));
            end
        end
        m_axis_tready <= quiet || ($urandom_range(99) >= 11);
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Field extremes, one-element vectors, truncation of the root and a short
    // run of full-scale pairs.
    task automatic test_directed_cases();
        send_pair(0, 0, 1'b1);                 // zero distance
        send_pair(1, 0, 1'b1);                 // one LSB apart
        send_pair(0, 1, 1'b1);
        send_pair(3, 2, 1'b0);                 // sum of 2 truncates to 1
        send_pair(2, 1, 1'b1);
        send_pair(MOST_POS, MOST_NEG, 1'b1);   // largest difference, both signs
        send_pair(MOST_NEG, MOST_POS, 1'b1);
        send_pair(MOST_NEG, MOST_NEG, 1'b1);
        send_pair(MOST_POS, MOST_POS, 1'b1);
        send_pair(-256, 0, 1'b0);              // 1.0 and 1.0 apart: root of two
        send_pair(0, -256, 1'b1);
        send_pair(MOST_POS, MOST_NEG, 1'b0);
        send_pair(MOST_NEG, MOST_POS, 1'b0);
        send_pair(MOST_POS, MOST_NEG, 1'b0);
        send_pair(256, -256, 1'b1);
        send_pair(5, 2, 1'b0);
        send_pair(-7, 9, 1'b0);
        send_pair(100, -100, 1'b1);
        hold_until_drained();
    endtask

    // A long vector of full-scale pairs that drives the sum far up the
    // accumulator, then a short one to see it start again from zero.
    task automatic test_long_vector();
        for (int i = 0; i < LONG_LENGTH; i++)
            send_pair(i[0] ? MOST_POS : MOST_NEG, i[0] ? MOST_NEG : MOST_POS,
                      i == LONG_LENGTH - 1);
        send_pair(3, 0, 1'b1);
        hold_until_drained();
    endtask

    // Random vectors, mostly short, a few long. A stretch in the middle runs
    // without stalls; every so often hold off until the unit has emptied.
    task automatic test_random_vectors(input int pair_budget);
        int sent;
        int len;
        int count;
        sent  = 0;
        count = 0;
        while (sent < pair_budget)
        begin
            len = ($urandom_range(19) == 0) ? $urandom_range(17, 200)
                                            : $urandom_range(1, 16);
            quiet = (sent >= pair_budget / 3) && (sent < pair_budget / 2);
            for (int i = 0; i < len; i++)
                send_pair(pick_element(), pick_element(), i == len - 1);
            sent += len;
            count++;
            if (count % 25 == 0)
                hold_until_drained();
        end
        quiet = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_long_vector();
        test_random_vectors(1400);

        // Let the last root finish and catch any stray beat.
        hold_until_drained();
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Run covered %0d vectors (%0d element pairs); %0d distances checked, %0d saturated.",
                 vectors_sent, pairs_sent, distances_seen, clipped_seen);
        $display("Mismatches: %0d.", mismatches);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Guard against a hang: far beyond the slowest correct run.
    initial
    begin
        #10_000_000;
        $display("Timed out with %0d distances still owed.", distances_due.size());
        $display("TB_ERROR");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/edu_pkg.sv
hw/rtl/edu_ctrl.sv
hw/rtl/edu_datapath.sv
hw/rtl/euclidean_distance_unit.sv
bench/tb_euclidean_distance_unit.sv
